/* hdl/ntc_pkg.sv */
// shared constants, types and codes for the ntc thermistor converter
package ntc_pkg;

    localparam int ADC_FULL_SCALE = 4095;

    localparam int ADC_W   = 12;
    localparam int TEMP_W  = 15;
    localparam int COEF_W  = 48;
    localparam int OHM_W   = 16;
    localparam int APB_AW  = 6;
    localparam int APB_DW  = 64;

    // log2 unit
    localparam int RAW_W   = 40;
    localparam int FRAC_W  = 24;
    localparam int EXP_W   = 6;
    localparam int MANT_W  = 31;
    localparam int LOG_W   = EXP_W + FRAC_W;
    localparam int LOG_LAT = FRAC_W + 2;

    // polynomial
    localparam int LN_W       = 32;
    localparam int ACC_W      = 64;
    localparam int MAG_W      = 63;
    localparam int HORNER_LAT = 5;

    // stages ahead of the reciprocal
    localparam int PRE_DEPTH = 1 + LOG_LAT + 2 + 3 * HORNER_LAT;

    // reciprocal
    localparam int DIV_BITS = 16;
    localparam int DIV_W    = MAG_W + DIV_BITS;

    localparam logic [RAW_W-1:0] TOP_SCALE  = RAW_W'(50 * ADC_FULL_SCALE);
    localparam logic [RAW_W-1:0] CODE_MULT  = RAW_W'(33);
    localparam logic [31:0]      LN2_Q32    = 32'd2977044472;
    localparam logic [MAG_W-1:0] RECIP_NUM  = MAG_W'(100) << 44;
    localparam logic [MAG_W-1:0] SAT_MAG    = MAG_W'(1) << 62;
    localparam logic signed [ACC_W-1:0] SAT_HI = 64'sh4000_0000_0000_0000;
    localparam logic signed [ACC_W-1:0] SAT_LO = -64'sh4000_0000_0000_0000;

    localparam int KELVIN_CENTI = 27315;
    localparam int TEMP_HI      = 15000;
    localparam int TEMP_LO      = -4000;

    localparam logic [COEF_W-1:0] COEF_A_RST = 48'd59004473468;
    localparam logic [COEF_W-1:0] COEF_B_RST = 48'd4402884362;
    localparam logic [COEF_W-1:0] COEF_C_RST = 48'd42739337;
    localparam logic [COEF_W-1:0] COEF_D_RST = 48'hFFFF_FFEC_5F2B;
    localparam logic [OHM_W-1:0]  DIV_RST    = 16'd280;
    localparam logic [OHM_W-1:0]  NOM_RST    = 16'd2752;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_HIGH = 2'd1,
        ST_LOW  = 2'd2,
        ST_ZERO = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_COEF_A  = 3'd0,
        REG_COEF_B  = 3'd1,
        REG_COEF_C  = 3'd2,
        REG_COEF_D  = 3'd3,
        REG_DIVIDER = 3'd4,
        REG_NOMINAL = 3'd5
    } reg_idx_t;

    // control that rides along with each word
    typedef struct packed {
        logic    vld;
        logic    spec;
        status_t st;
    } side_t;

endpackage

/* hdl/ntc_in_if.sv */
// input word channel: raw adc code
interface ntc_in_if;
    logic                      valid;
    logic                      ready;
    logic [ntc_pkg::ADC_W-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

/* hdl/ntc_out_if.sv */
// output word channel: temperature and status
interface ntc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ntc_pkg::TEMP_W-1:0] temp_centi_c;
    logic [1:0]                        status;

    modport source (output valid, output temp_centi_c, output status, input ready);
    modport sink   (input valid, input temp_centi_c, input status, output ready);
endinterface

/* hdl/ntc_log2.sv */
// pipelined q24 log2: normalize, then one squaring step per stage
module ntc_log2 (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ntc_pkg::RAW_W-1:0]     x,
    output logic [ntc_pkg::LOG_W-1:0]     log_q24
);

    logic [ntc_pkg::RAW_W-1:0]  x_reg;
    logic [ntc_pkg::EXP_W-1:0]  e_reg;
    logic [ntc_pkg::EXP_W-1:0]  e_next;
    logic [ntc_pkg::RAW_W-1:0]  shifted;

    logic [ntc_pkg::MANT_W-1:0] m_reg  [0:ntc_pkg::FRAC_W];
    logic [ntc_pkg::FRAC_W-1:0] f_reg  [0:ntc_pkg::FRAC_W];
    logic [ntc_pkg::EXP_W-1:0]  ex_reg [0:ntc_pkg::FRAC_W];

    // leading one
    always_comb
    begin
        e_next = '0;
        for (int i = 0; i < ntc_pkg::RAW_W; i++)
        begin
            if (x[i])
            begin
                e_next = ntc_pkg::EXP_W'(i);
            end
        end
    end

    assign shifted = x_reg << (ntc_pkg::EXP_W'(ntc_pkg::RAW_W - 1) - e_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x;
            e_reg     <= e_next;
            m_reg[0]  <= shifted[ntc_pkg::RAW_W-1 -: ntc_pkg::MANT_W];
            f_reg[0]  <= '0;
            ex_reg[0] <= e_reg;
        end
    end

    for (genvar k = 0; k < ntc_pkg::FRAC_W; k++)
    begin : g_sq
        logic [2*ntc_pkg::MANT_W-1:0] sq;
        logic [ntc_pkg::MANT_W:0]     s;

        assign sq = (2*ntc_pkg::MANT_W)'(m_reg[k]) * (2*ntc_pkg::MANT_W)'(m_reg[k]);
        assign s  = sq[2*ntc_pkg::MANT_W-1 -: ntc_pkg::MANT_W+1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ex_reg[k+1] <= ex_reg[k];
                if (s[ntc_pkg::MANT_W])
                begin
                    m_reg[k+1] <= s[ntc_pkg::MANT_W:1];
                    f_reg[k+1] <= {f_reg[k][ntc_pkg::FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    m_reg[k+1] <= s[ntc_pkg::MANT_W-1:0];
                    f_reg[k+1] <= {f_reg[k][ntc_pkg::FRAC_W-2:0], 1'b0};
                end
            end
        end
    end

    assign log_q24 = {ex_reg[ntc_pkg::FRAC_W], f_reg[ntc_pkg::FRAC_W]};

endmodule

/* hdl/ntc_horner.sv */
// one horner step: t_out = sat(coef + round(t_in * l_in / 2^24)), five stages
module ntc_horner (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [ntc_pkg::COEF_W-1:0] coef,
    input  logic signed [ntc_pkg::ACC_W-1:0]  t_in,
    input  logic signed [ntc_pkg::LN_W-1:0]   l_in,
    output logic signed [ntc_pkg::ACC_W-1:0]  t_out,
    output logic signed [ntc_pkg::LN_W-1:0]   l_out
);

    localparam int UB_W = ntc_pkg::LN_W - 1;
    localparam int UH_W = ntc_pkg::MAG_W - 32;
    localparam int P0_W = 32 + UB_W;
    localparam int HI_W = UH_W + UB_W;
    localparam int P_W  = HI_W + 32;
    localparam int R_W  = P_W - 24;

    logic signed [ntc_pkg::ACC_W-1:0] ta;
    logic signed [ntc_pkg::LN_W-1:0]  la;

    logic                      neg1_reg, neg2_reg, neg3_reg;
    logic [ntc_pkg::MAG_W-1:0] ua1_reg;
    logic [UB_W-1:0]           ub1_reg, ub2_reg;
    logic [UH_W-1:0]           uh2_reg;
    logic [P0_W-1:0]           p0_reg;
    logic [P0_W-1:0]           p0_next;
    logic [HI_W-1:0]           hi_prod;
    logic [P_W-1:0]            p3_reg;
    logic [P_W-1:0]            p3_next;
    logic [P_W-1:0]            pr;
    logic [R_W-1:0]            r;
    logic [ntc_pkg::MAG_W-1:0] rc;
    logic signed [ntc_pkg::ACC_W-1:0] s4_reg, s4_next;
    logic signed [ntc_pkg::ACC_W-1:0] sum;
    logic signed [ntc_pkg::ACC_W-1:0] sum_reg, sum_next;
    logic signed [ntc_pkg::LN_W-1:0]  l_reg [0:ntc_pkg::HORNER_LAT-1];

    assign ta = t_in[ntc_pkg::ACC_W-1] ? -t_in : t_in;
    assign la = l_in[ntc_pkg::LN_W-1] ? -l_in : l_in;

    assign p0_next = P0_W'(ua1_reg[31:0]) * P0_W'(ub1_reg);
    assign hi_prod = HI_W'(uh2_reg) * HI_W'(ub2_reg);
    assign p3_next = {hi_prod, 32'b0} + P_W'(p0_reg);

    // round half away from zero on the magnitude, then clamp
    assign pr = p3_reg + (P_W'(1) << 23);
    assign r  = pr[P_W-1:24];
    assign rc = (r > R_W'(ntc_pkg::SAT_MAG)) ? ntc_pkg::SAT_MAG : r[ntc_pkg::MAG_W-1:0];
    assign s4_next = neg3_reg ? -$signed({1'b0, rc}) : $signed({1'b0, rc});

    assign sum = ntc_pkg::ACC_W'(coef) + s4_reg;
    always_comb
    begin
        priority if (sum > ntc_pkg::SAT_HI)
        begin
            sum_next = ntc_pkg::SAT_HI;
        end
        else if (sum < ntc_pkg::SAT_LO)
        begin
            sum_next = ntc_pkg::SAT_LO;
        end
        else
        begin
            sum_next = sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= t_in[ntc_pkg::ACC_W-1] ^ l_in[ntc_pkg::LN_W-1];
            ua1_reg  <= ta[ntc_pkg::MAG_W-1:0];
            ub1_reg  <= la[UB_W-1:0];

            neg2_reg <= neg1_reg;
            p0_reg   <= p0_next;
            uh2_reg  <= ua1_reg[ntc_pkg::MAG_W-1:32];
            ub2_reg  <= ub1_reg;

            neg3_reg <= neg2_reg;
            p3_reg   <= p3_next;

            s4_reg   <= s4_next;
            sum_reg  <= sum_next;

            l_reg[0] <= l_in;
            for (int i = 1; i < ntc_pkg::HORNER_LAT; i++)
            begin
                l_reg[i] <= l_reg[i-1];
            end
        end
    end

    assign t_out = sum_reg;
    assign l_out = l_reg[ntc_pkg::HORNER_LAT-1];

endmodule

/* hdl/ntc_thermistor_to_celsius_core.sv */
// top level: adc code to hundredths of a degree celsius, apb register port
//
// usage
//   in_ch carries one 12 bit adc code per word, out_ch one temperature word
//   (temp_centi_c, signed hundredths of a degree, plus a 2 bit status:
//   0 in range, 1 clamped high, 2 clamped low, 3 zero code or zero divider).
//   every input word yields exactly one output word, in order.
//   the coefficients and resistor values sit behind an apb port, one 64 bit
//   register per 8 byte slot; write them only while no word is in flight.
// timing
//   one word per cycle sustained while out_ch takes results. each word
//   passes 1 input stage, 26 stages of log2 (normalize, then one squaring
//   per stage), 2 for the ln scaling, 3 x 5 horner stages, 1 reciprocal
//   setup and 16 quotient-bit stages, then the output register.
// stall
//   the whole pipe moves together; when a valid result sits in the output
//   register and out_ch is not ready, every stage holds and in_ch.ready
//   drops, so nothing is lost or repeated. bubbles flow as invalid stages.
// reset
//   rst_n clears all valid bits and loads the documented coefficient set.
module ntc_thermistor_to_celsius_core (
    input  logic                          clk,
    input  logic                          rst_n,
    ntc_in_if.sink                        in_ch,
    ntc_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ntc_pkg::APB_AW-1:0]    paddr,
    input  logic [ntc_pkg::APB_DW-1:0]    pwdata,
    output logic [ntc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ntc_pkg::COEF_W-1:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic [ntc_pkg::OHM_W-1:0]  divider_reg, nominal_reg;
    logic [2:0]                 reg_idx;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ntc_pkg::APB_AW-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg  <= ntc_pkg::COEF_A_RST;
            coef_b_reg  <= ntc_pkg::COEF_B_RST;
            coef_c_reg  <= ntc_pkg::COEF_C_RST;
            coef_d_reg  <= ntc_pkg::COEF_D_RST;
            divider_reg <= ntc_pkg::DIV_RST;
            nominal_reg <= ntc_pkg::NOM_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ntc_pkg::REG_COEF_A:  coef_a_reg  <= pwdata[ntc_pkg::COEF_W-1:0];
                ntc_pkg::REG_COEF_B:  coef_b_reg  <= pwdata[ntc_pkg::COEF_W-1:0];
                ntc_pkg::REG_COEF_C:  coef_c_reg  <= pwdata[ntc_pkg::COEF_W-1:0];
                ntc_pkg::REG_COEF_D:  coef_d_reg  <= pwdata[ntc_pkg::COEF_W-1:0];
                ntc_pkg::REG_DIVIDER: divider_reg <= pwdata[ntc_pkg::OHM_W-1:0];
                ntc_pkg::REG_NOMINAL: nominal_reg <= pwdata[ntc_pkg::OHM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ntc_pkg::REG_COEF_A:  prdata = ntc_pkg::APB_DW'(coef_a_reg);
            ntc_pkg::REG_COEF_B:  prdata = ntc_pkg::APB_DW'(coef_b_reg);
            ntc_pkg::REG_COEF_C:  prdata = ntc_pkg::APB_DW'(coef_c_reg);
            ntc_pkg::REG_COEF_D:  prdata = ntc_pkg::APB_DW'(coef_d_reg);
            ntc_pkg::REG_DIVIDER: prdata = ntc_pkg::APB_DW'(divider_reg);
            ntc_pkg::REG_NOMINAL: prdata = ntc_pkg::APB_DW'(nominal_reg);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipe advance: everything moves unless a finished word is blocked
    // ------------------------------------------------------------------
    logic out_vld_reg;
    logic adv;

    assign adv         = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // ------------------------------------------------------------------
    // input stage: divider ratio as two integers, special codes
    // ------------------------------------------------------------------
    logic [ntc_pkg::RAW_W-1:0] code33;
    logic [ntc_pkg::RAW_W-1:0] num_reg, den_reg, num_next, den_next;
    ntc_pkg::side_t            side0_next;
    ntc_pkg::side_t            side_reg [0:ntc_pkg::PRE_DEPTH-1];

    assign code33   = ntc_pkg::RAW_W'(in_ch.adc_code) * ntc_pkg::CODE_MULT;
    assign num_next = code33 * ntc_pkg::RAW_W'(divider_reg);
    assign den_next = (ntc_pkg::TOP_SCALE - code33) * ntc_pkg::RAW_W'(nominal_reg);

    always_comb
    begin
        side0_next.vld = in_ch.valid;
        priority if (in_ch.adc_code == '0 || divider_reg == '0)
        begin
            side0_next.spec = 1'b1;
            side0_next.st   = ntc_pkg::ST_ZERO;
        end
        else if (code33 >= ntc_pkg::TOP_SCALE || nominal_reg == '0)
        begin
            // divider at or above the supply, or no nominal: infinite ratio
            side0_next.spec = 1'b1;
            side0_next.st   = ntc_pkg::ST_LOW;
        end
        else
        begin
            side0_next.spec = 1'b0;
            side0_next.st   = ntc_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    // control travels alongside the datapath, one entry per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ntc_pkg::PRE_DEPTH; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            side_reg[0] <= side0_next;
            for (int i = 1; i < ntc_pkg::PRE_DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // log2 of numerator and denominator, in parallel
    // ------------------------------------------------------------------
    logic [ntc_pkg::LOG_W-1:0] log_num, log_den;

    ntc_log2 u_log_num (
        .clk     (clk),
        .en      (adv),
        .x       (num_reg),
        .log_q24 (log_num)
    );

    ntc_log2 u_log_den (
        .clk     (clk),
        .en      (adv),
        .x       (den_reg),
        .log_q24 (log_den)
    );

    // ------------------------------------------------------------------
    // ln ratio = (log2 num - log2 den) * ln 2, rounded half away from zero
    // ------------------------------------------------------------------
    logic signed [ntc_pkg::LOG_W:0]   diff;
    logic signed [ntc_pkg::LOG_W:0]   diff_abs;
    logic [ntc_pkg::LOG_W-1:0]        mag_reg;
    logic                             dneg_reg;
    logic [ntc_pkg::LOG_W+31:0]       ln_prod;
    logic [ntc_pkg::LOG_W-1:0]        ln_mag;
    logic signed [ntc_pkg::LN_W-1:0]  lnq_reg, lnq_next;

    assign diff     = $signed({1'b0, log_num}) - $signed({1'b0, log_den});
    assign diff_abs = diff[ntc_pkg::LOG_W] ? -diff : diff;

    assign ln_prod  = (ntc_pkg::LOG_W+32)'(mag_reg) * (ntc_pkg::LOG_W+32)'(ntc_pkg::LN2_Q32)
                    + ((ntc_pkg::LOG_W+32)'(1) << 31);
    assign ln_mag   = ln_prod[ntc_pkg::LOG_W+31:32];
    assign lnq_next = dneg_reg ? -$signed(ntc_pkg::LN_W'(ln_mag))
                               :  $signed(ntc_pkg::LN_W'(ln_mag));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg  <= diff_abs[ntc_pkg::LOG_W-1:0];
            dneg_reg <= diff[ntc_pkg::LOG_W];
            lnq_reg  <= lnq_next;
        end
    end

    // ------------------------------------------------------------------
    // extended steinhart-hart cubic, horner form, q44
    // ------------------------------------------------------------------
    logic signed [ntc_pkg::ACC_W-1:0] t1, t2, inv;
    logic signed [ntc_pkg::LN_W-1:0]  l1, l2;

    ntc_horner u_h_c (
        .clk   (clk),
        .en    (adv),
        .coef  ($signed(coef_c_reg)),
        .t_in  (ntc_pkg::ACC_W'($signed(coef_d_reg))),
        .l_in  (lnq_reg),
        .t_out (t1),
        .l_out (l1)
    );

    ntc_horner u_h_b (
        .clk   (clk),
        .en    (adv),
        .coef  ($signed(coef_b_reg)),
        .t_in  (t1),
        .l_in  (l1),
        .t_out (t2),
        .l_out (l2)
    );

    ntc_horner u_h_a (
        .clk   (clk),
        .en    (adv),
        .coef  ($signed(coef_a_reg)),
        .t_in  (t2),
        .l_in  (l2),
        .t_out (inv),
        .l_out ()
    );

    // ------------------------------------------------------------------
    // reciprocal: centi-kelvin = (100*2^44 + inv/2) / inv, restoring,
    // one quotient bit per stage; a quotient past 16 bits only saturates
    // ------------------------------------------------------------------
    logic [ntc_pkg::MAG_W-1:0]    inv_u;
    logic [ntc_pkg::MAG_W-1:0]    rnum;
    logic                         ovf_next;
    ntc_pkg::side_t               r0_side;

    logic [ntc_pkg::DIV_W-1:0]    rem_reg  [0:ntc_pkg::DIV_BITS];
    logic [ntc_pkg::MAG_W-1:0]    dv_reg   [0:ntc_pkg::DIV_BITS];
    logic [ntc_pkg::DIV_BITS-1:0] q_reg    [0:ntc_pkg::DIV_BITS];
    logic                         ovf_reg  [0:ntc_pkg::DIV_BITS];
    ntc_pkg::side_t               dside_reg[0:ntc_pkg::DIV_BITS];

    assign inv_u    = inv[ntc_pkg::MAG_W-1:0];
    assign rnum     = ntc_pkg::RECIP_NUM + {1'b0, inv_u[ntc_pkg::MAG_W-1:1]};
    assign ovf_next = ntc_pkg::DIV_W'(rnum) >= {inv_u, ntc_pkg::DIV_BITS'(0)};

    // cubic at or below zero: infinite or negative kelvin
    always_comb
    begin
        r0_side = side_reg[ntc_pkg::PRE_DEPTH-1];
        if (!r0_side.spec)
        begin
            if (inv == '0)
            begin
                r0_side.spec = 1'b1;
                r0_side.st   = ntc_pkg::ST_HIGH;
            end
            else if (inv[ntc_pkg::ACC_W-1])
            begin
                r0_side.spec = 1'b1;
                r0_side.st   = ntc_pkg::ST_LOW;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= ntc_pkg::DIV_W'(rnum);
            dv_reg[0]  <= inv_u;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= ntc_pkg::DIV_BITS; i++)
            begin
                dside_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            dside_reg[0] <= r0_side;
            for (int i = 1; i <= ntc_pkg::DIV_BITS; i++)
            begin
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    for (genvar j = 0; j < ntc_pkg::DIV_BITS; j++)
    begin : g_div
        localparam int SH = ntc_pkg::DIV_BITS - 1 - j;
        logic [ntc_pkg::DIV_W:0] trial;
        logic                    take;

        assign trial = {1'b0, rem_reg[j]}
                     - {1'b0, ntc_pkg::DIV_W'(dv_reg[j]) << SH};
        assign take  = !trial[ntc_pkg::DIV_W];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j+1] <= take ? trial[ntc_pkg::DIV_W-1:0] : rem_reg[j];
                dv_reg[j+1]  <= dv_reg[j];
                q_reg[j+1]   <= {q_reg[j][ntc_pkg::DIV_BITS-2:0], take};
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // kelvin to celsius, clamp, output register
    // ------------------------------------------------------------------
    localparam int TC_W = ntc_pkg::DIV_BITS + 2;

    ntc_pkg::side_t                 fin_side;
    logic signed [TC_W-1:0]         tc;
    logic signed [ntc_pkg::TEMP_W-1:0] temp_next, temp_reg;
    ntc_pkg::status_t               status_next, status_reg;

    assign fin_side = dside_reg[ntc_pkg::DIV_BITS];
    assign tc = $signed({2'b0, q_reg[ntc_pkg::DIV_BITS]})
              - $signed(TC_W'(ntc_pkg::KELVIN_CENTI));

    always_comb
    begin
        if (fin_side.spec)
        begin
            status_next = fin_side.st;
            unique case (fin_side.st)
                ntc_pkg::ST_HIGH: temp_next = ntc_pkg::TEMP_W'(ntc_pkg::TEMP_HI);
                ntc_pkg::ST_LOW:  temp_next = ntc_pkg::TEMP_W'(ntc_pkg::TEMP_LO);
                ntc_pkg::ST_ZERO: temp_next = '0;
                ntc_pkg::ST_OK:   temp_next = '0;
            endcase
        end
        else if (ovf_reg[ntc_pkg::DIV_BITS] || tc > TC_W'(ntc_pkg::TEMP_HI))
        begin
            status_next = ntc_pkg::ST_HIGH;
            temp_next   = ntc_pkg::TEMP_W'(ntc_pkg::TEMP_HI);
        end
        else if (tc < TC_W'(ntc_pkg::TEMP_LO))
        begin
            status_next = ntc_pkg::ST_LOW;
            temp_next   = ntc_pkg::TEMP_W'(ntc_pkg::TEMP_LO);
        end
        else
        begin
            status_next = ntc_pkg::ST_OK;
            temp_next   = tc[ntc_pkg::TEMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= fin_side.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            temp_reg   <= temp_next;
            status_reg <= status_next;
        end
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.temp_centi_c = temp_reg;
    assign out_ch.status       = status_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_zero_code_temp: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && status_reg == ntc_pkg::ST_ZERO |-> temp_reg == '0)
        else $error("zero-code word with nonzero temperature");

    a_high_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && status_reg == ntc_pkg::ST_HIGH
            |-> temp_reg == ntc_pkg::TEMP_W'(ntc_pkg::TEMP_HI))
        else $error("high clamp status without high limit");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && status_reg == ntc_pkg::ST_OK
            |-> temp_reg <= ntc_pkg::TEMP_W'(ntc_pkg::TEMP_HI)
             && temp_reg >= ntc_pkg::TEMP_W'(ntc_pkg::TEMP_LO))
        else $error("in-range status with temperature outside limits");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(side_reg[0]) && $stable(dside_reg[0]))
        else $error("pipeline control moved during a stall");

endmodule
